@@ design/lbb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

	localparam int ADC_MAX        = 1023;
	localparam int PHASE_BITS_DEF = 10;

	localparam int RD_W      = 10;
	localparam int BR_W      = 8;
	localparam int CFG_W     = 16;
	localparam int ELAPSED_W = 32;
	localparam int FRAC_W    = 16;
	localparam int MUL_W     = 16;
	localparam int CIDX_W    = 2;
	localparam int MODE_W    = 2;

	localparam int BR_MAX   = (1 << BR_W) - 1;
	localparam int FRAC_MAX = (1 << FRAC_W) - 1;
	localparam int RD_MAX   = (1 << RD_W) - 1;

	// quotient widths of the two divisions by the adc full scale
	localparam int PEAK_Q_W = $clog2(RD_MAX * BR_MAX / ADC_MAX + 1);
	localparam int SPAN_Q_W = $clog2(RD_MAX * FRAC_MAX / ADC_MAX + 1);
	localparam int PER_W    = ((SPAN_Q_W > CFG_W) ? SPAN_Q_W : CFG_W) + 1;
	localparam int QCNT_W   = $clog2(ELAPSED_W + 1);

	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_FLOOR = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_PMIN  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PSPAN = 2'd2;

	localparam logic [BR_W-1:0]  FLOOR_RST = 8'd10;
	localparam logic [CFG_W-1:0] PMIN_RST  = 16'd100;
	localparam logic [CFG_W-1:0] PSPAN_RST = 16'd4000;

	typedef struct packed {
		logic              start;
		logic [QCNT_W-1:0] qbits;
	} lbb_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lbb_calc_st_t;

endpackage

`default_nettype wire

@@ design/lbb_sdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
// the caller preloads the partial remainder with the numerator bits above the
// quotient (always below the divisor) and left-aligns the remaining bits in lo
module lbb_sdiv #(
	parameter int DEN_W = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lbb_pkg::lbb_div_ctl_t          ctl,
	input  logic [DEN_W-1:0]               hi,
	input  logic [lbb_pkg::ELAPSED_W-1:0]  lo,
	input  logic [DEN_W-1:0]               den,
	output logic [lbb_pkg::ELAPSED_W-1:0]  quo,
	output logic [DEN_W-1:0]               rem,
	output logic                           done
);
	import lbb_pkg::*;

	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [ELAPSED_W-1:0] lo_q;
	logic [ELAPSED_W-1:0] quo_q;
	logic [QCNT_W-1:0]    cnt_q;
	logic                 done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] trial;
	logic           take;

	always_comb begin
		shifted = {rem_q, lo_q[ELAPSED_W-1]};
		trial   = shifted - {1'b0, den_q};
		take    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= ctl.qbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= hi;
			lo_q  <= lo;
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[ELAPSED_W-2:0], take};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ design/lbb_smul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle, lsb first
module lbb_smul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lbb_pkg::MUL_W-1:0]    a,
	input  logic [lbb_pkg::MUL_W-1:0]    b,
	output logic [2*lbb_pkg::MUL_W-1:0]  prod,
	output logic                         done
);
	import lbb_pkg::*;

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [MUL_W-1:0]   a_q;
	logic [2*MUL_W-1:0] p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [MUL_W:0]     sum;

	always_comb begin
		sum = {1'b0, p_q[2*MUL_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(MUL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			p_q <= {sum, p_q[MUL_W-1:1]};
		end
	end

	assign prod = p_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ design/lbb_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none

// sequencer for one sample: peak, period, phase, sine, raised cosine, scale
module lbb_calc #(
	parameter int PHASE_BITS = lbb_pkg::PHASE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lbb_pkg::RD_W-1:0]      power,
	input  logic [lbb_pkg::RD_W-1:0]      blink,
	input  logic [lbb_pkg::ELAPSED_W-1:0] elapsed,
	input  logic [lbb_pkg::BR_W-1:0]      pfloor,
	input  logic [lbb_pkg::CFG_W-1:0]     pmin,
	input  logic [lbb_pkg::CFG_W-1:0]     pspan,
	output lbb_pkg::lbb_calc_st_t         st,
	output logic [lbb_pkg::BR_W-1:0]      result
);
	import lbb_pkg::*;

	localparam int PW_W  = RD_W + BR_W;
	localparam int U_W   = 2 * PHASE_BITS;
	localparam int D_W   = 2 * PHASE_BITS + 3;
	localparam int SN_W  = U_W + FRAC_W + 4;
	localparam int DW_A  = (PER_W > D_W) ? PER_W : D_W;
	localparam int DEN_W = (DW_A > FRAC_W) ? DW_A : FRAC_W;

	localparam logic [PHASE_BITS:0] N_VAL  = (PHASE_BITS + 1)'(1) << PHASE_BITS;
	localparam logic [D_W-1:0]      D_BASE = D_W'(5) << (2 * PHASE_BITS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PEAK,
		S_SMUL,
		S_SDIV,
		S_MOD,
		S_PHASE,
		S_UMUL,
		S_SIN,
		S_FMUL,
		S_FDIV,
		S_BMUL,
		S_BDIV
	} state_t;

	state_t               state_q;
	lbb_div_ctl_t         div_ctl_q;
	logic [DEN_W-1:0]     div_hi_q;
	logic [ELAPSED_W-1:0] div_lo_q;
	logic [DEN_W-1:0]     div_den_q;
	logic                 mul_start_q;
	logic [MUL_W-1:0]     mul_a_q;
	logic [MUL_W-1:0]     mul_b_q;
	logic [RD_W-1:0]      blink_q;
	logic [BR_W-1:0]      peak_q;
	logic [BR_W-1:0]      result_q;
	logic                 done_q;

	logic [ELAPSED_W-1:0] div_quo;
	logic [DEN_W-1:0]     div_rem;
	logic                 div_done;
	logic [2*MUL_W-1:0]   mul_prod;
	logic                 mul_done;

	logic [PW_W-1:0]       pw;
	logic [BR_W-1:0]       peak_raw;
	logic [BR_W-1:0]       peak_next;
	logic [PER_W-1:0]      period_next;
	logic [PHASE_BITS:0]   nmp;
	logic [U_W-1:0]        u_next;
	logic [D_W-1:0]        d_next;
	logic [SN_W-1:0]       snum;

	lbb_sdiv #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl_q),
		.hi     (div_hi_q),
		.lo     (div_lo_q),
		.den    (div_den_q),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	lbb_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	always_comb begin
		// power * 255 as a shift and subtract
		pw          = (PW_W'(power) << BR_W) - PW_W'(power);
		peak_raw    = (div_quo > ELAPSED_W'(BR_MAX)) ? BR_W'(BR_MAX) : div_quo[BR_W-1:0];
		peak_next   = (peak_raw < pfloor) ? pfloor : peak_raw;
		period_next = PER_W'(pmin) + PER_W'(div_quo[SPAN_Q_W-1:0]);
		nmp         = N_VAL - {1'b0, div_quo[PHASE_BITS-1:0]};
		u_next      = mul_prod[U_W-1:0];
		d_next      = D_BASE - D_W'({u_next, 2'b00});
		// u * 65535 * 16
		snum        = (SN_W'(u_next) << (FRAC_W + 4)) - (SN_W'(u_next) << 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_ctl_q   <= '0;
			div_hi_q    <= '0;
			div_lo_q    <= '0;
			div_den_q   <= '0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			blink_q     <= '0;
			peak_q      <= '0;
			result_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			div_ctl_q.start <= 1'b0;
			mul_start_q     <= 1'b0;
			done_q          <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						blink_q         <= blink;
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(PEAK_Q_W);
						div_hi_q        <= DEN_W'(pw >> PEAK_Q_W);
						div_lo_q        <= ELAPSED_W'(pw[PEAK_Q_W-1:0]) << (ELAPSED_W - PEAK_Q_W);
						div_den_q       <= DEN_W'(ADC_MAX);
						state_q         <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (div_done) begin
						peak_q      <= peak_next;
						mul_start_q <= 1'b1;
						mul_a_q     <= pspan;
						mul_b_q     <= MUL_W'(blink_q);
						state_q     <= S_SMUL;
					end
				end
				S_SMUL: begin
					if (mul_done) begin
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(SPAN_Q_W);
						div_hi_q        <= DEN_W'(mul_prod >> SPAN_Q_W);
						div_lo_q        <= ELAPSED_W'(mul_prod[SPAN_Q_W-1:0])
						                   << (ELAPSED_W - SPAN_Q_W);
						state_q         <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_done) begin
						if (period_next == '0) begin
							// zero period: phase taken as zero
							mul_start_q <= 1'b1;
							mul_a_q     <= MUL_W'(N_VAL);
							mul_b_q     <= '0;
							state_q     <= S_UMUL;
						end else begin
							div_ctl_q.start <= 1'b1;
							div_ctl_q.qbits <= QCNT_W'(ELAPSED_W);
							div_hi_q        <= '0;
							div_lo_q        <= elapsed;
							div_den_q       <= DEN_W'(period_next);
							state_q         <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (div_done) begin
						// (elapsed mod period) << PHASE_BITS over period
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(PHASE_BITS);
						div_hi_q        <= div_rem;
						div_lo_q        <= '0;
						state_q         <= S_PHASE;
					end
				end
				S_PHASE: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= MUL_W'(nmp);
						mul_b_q     <= MUL_W'(div_quo[PHASE_BITS-1:0]);
						state_q     <= S_UMUL;
					end
				end
				S_UMUL: begin
					if (mul_done) begin
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(FRAC_W);
						div_hi_q        <= DEN_W'(snum >> FRAC_W);
						div_lo_q        <= {snum[FRAC_W-1:0], {(ELAPSED_W - FRAC_W){1'b0}}};
						div_den_q       <= DEN_W'(d_next);
						state_q         <= S_SIN;
					end
				end
				S_SIN: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= div_quo[MUL_W-1:0];
						mul_b_q     <= div_quo[MUL_W-1:0];
						state_q     <= S_FMUL;
					end
				end
				S_FMUL: begin
					if (mul_done) begin
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(FRAC_W);
						div_hi_q        <= DEN_W'(mul_prod[2*MUL_W-1:FRAC_W]);
						div_lo_q        <= {mul_prod[FRAC_W-1:0], {(ELAPSED_W - FRAC_W){1'b0}}};
						div_den_q       <= DEN_W'(FRAC_MAX);
						state_q         <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= div_quo[MUL_W-1:0];
						mul_b_q     <= MUL_W'(peak_q - pfloor);
						state_q     <= S_BMUL;
					end
				end
				S_BMUL: begin
					if (mul_done) begin
						div_ctl_q.start <= 1'b1;
						div_ctl_q.qbits <= QCNT_W'(BR_W);
						div_hi_q        <= DEN_W'(mul_prod >> BR_W);
						div_lo_q        <= ELAPSED_W'(mul_prod[BR_W-1:0]) << (ELAPSED_W - BR_W);
						state_q         <= S_BDIV;
					end
				end
				S_BDIV: begin
					if (div_done) begin
						result_q <= pfloor + div_quo[BR_W-1:0];
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign st.busy = (state_q != S_IDLE) || done_q;
	assign st.done = done_q;
	assign result  = result_q;

endmodule

`default_nettype wire

@@ design/led_breathing_brightness_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// LED breathing brightness generator. Each input beat is a millisecond tick
// (advances the elapsed counter, no output), a restart (clears the counter and
// returns brightness 0 at once) or a sample (returns a raised-cosine brightness
// between power_floor and the peak set by power_reading, over a period set by
// blink_reading). A restart holds in_stall while its zero sits in the result
// slot. A sample runs through one shared bit-serial divider and one shared
// bit-serial multiplier in turn; the 32-step division of the elapsed counter
// by the period is its longest single step, and a zero period skips that
// division. One finished result waits in the output register while the next
// beat is taken; in_stall is high while a sample is being worked on and while
// a result sits in the result slot, one cycle when the output register is free
// and longer behind a full one. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module led_breathing_brightness_top #(
	parameter int PHASE_BITS = lbb_pkg::PHASE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lbb_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [lbb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lbb_pkg::MODE_W-1:0]   mode,
	input  logic [lbb_pkg::RD_W-1:0]     power_reading,
	input  logic [lbb_pkg::RD_W-1:0]     blink_reading,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lbb_pkg::BR_W-1:0]     brightness
);
	import lbb_pkg::*;

	logic [BR_W-1:0]      power_floor_q;
	logic [CFG_W-1:0]     period_min_q;
	logic [CFG_W-1:0]     period_span_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 res_valid_q;
	logic [BR_W-1:0]      res_q;
	logic                 out_valid_q;
	logic [BR_W-1:0]      brightness_q;

	lbb_calc_st_t    st;
	logic [BR_W-1:0] calc_result;
	logic            in_acc;
	logic            calc_start;
	logic            restart_acc;
	logic            res_move;

	assign in_stall    = st.busy || res_valid_q;
	assign in_acc      = in_valid && !in_stall;
	assign calc_start  = in_acc && (mode == MODE_SAMPLE);
	assign restart_acc = in_acc && (mode == MODE_RESTART);
	assign res_move    = res_valid_q && (!out_valid_q || !out_stall);

	lbb_calc #(
		.PHASE_BITS (PHASE_BITS)
	) u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (calc_start),
		.power   (power_reading),
		.blink   (blink_reading),
		.elapsed (elapsed_q),
		.pfloor  (power_floor_q),
		.pmin    (period_min_q),
		.pspan   (period_span_q),
		.st      (st),
		.result  (calc_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_floor_q <= FLOOR_RST;
			period_min_q  <= PMIN_RST;
			period_span_q <= PSPAN_RST;
			elapsed_q     <= '0;
			res_valid_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FLOOR: power_floor_q <= cfg_data[BR_W-1:0];
					CFG_PMIN:  period_min_q  <= cfg_data;
					CFG_PSPAN: period_span_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				unique case (mode)
					MODE_TICK:    elapsed_q <= elapsed_q + 1'b1;
					MODE_RESTART: elapsed_q <= '0;
					default: ;
				endcase
			end
			if (st.done || restart_acc) begin
				res_valid_q <= 1'b1;
			end else if (res_move) begin
				res_valid_q <= 1'b0;
			end
			if (res_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st.done) begin
			res_q <= calc_result;
		end else if (restart_acc) begin
			res_q <= '0;
		end
		if (res_move) begin
			brightness_q <= res_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign brightness = brightness_q;

	// a finished sample always finds the result slot empty
	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> !res_valid_q)
		else $error("sample result finished while result slot was occupied");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		restart_acc |=> (res_valid_q && (res_q == '0) && (elapsed_q == '0)))
		else $error("restart beat did not clear the counter and queue a zero");

	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (mode == MODE_TICK)) |=> (elapsed_q == $past(elapsed_q + 1'b1)))
		else $error("tick beat did not advance the elapsed counter by one");

endmodule

`default_nettype wire
